// ===== src/module_heartbeat_watchdog_macros.svh =====
// Assertion macros shared by the heartbeat watchdog checker.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef MODULE_HEARTBEAT_WATCHDOG_MACROS_SVH
`define MODULE_HEARTBEAT_WATCHDOG_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHBWD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHBWD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mhbwd_pkg.sv =====
// Shared types and constants for the per-module heartbeat watchdog.
// No dependencies; used by the slot table and the top level.
package mhbwd_pkg;

	localparam int MODULES    = 16;
	localparam int SLOT_IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;
	localparam int REQ_W      = 4;
	localparam int COUNT_W    = 16;

	localparam logic [COUNT_W-1:0] STOP_LIMIT_RESET = 16'd100;

	typedef enum logic {
		CMD_HEARTBEAT = 1'b0,
		CMD_CHECK     = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FINE  = 2'd0,
		ST_PAUSE = 2'd1,
		ST_STOP  = 2'd2
	} slot_state_t;

	typedef struct packed {
		logic                timeout_error;
		slot_state_t         state;
		logic [COUNT_W-1:0]  missed;
	} slot_result_t;

endpackage

// ===== src/mhbwd_slot_table.sv =====
// Watchdog slot storage and the per-command read-modify-write update.
// Depends on mhbwd_pkg.
module mhbwd_slot_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	input  mhbwd_pkg::cmd_t                   cmd,
	input  logic [mhbwd_pkg::REQ_W-1:0]       slot,
	input  logic [mhbwd_pkg::COUNT_W-1:0]     stop_limit,
	output mhbwd_pkg::slot_result_t           result
);

	mhbwd_pkg::slot_state_t               state_q  [mhbwd_pkg::MODULES];
	logic [mhbwd_pkg::COUNT_W-1:0]        missed_q [mhbwd_pkg::MODULES];

	logic [mhbwd_pkg::SLOT_IDX_W-1:0]     idx;
	logic                                 in_range;
	mhbwd_pkg::slot_state_t               cur_state;
	logic [mhbwd_pkg::COUNT_W-1:0]        cur_missed;
	mhbwd_pkg::slot_result_t              upd;

	assign in_range   = (int'(slot) < mhbwd_pkg::MODULES);
	assign idx        = mhbwd_pkg::SLOT_IDX_W'(slot);
	assign cur_state  = state_q[idx];
	assign cur_missed = missed_q[idx];

	always_comb begin
		upd.timeout_error = 1'b0;
		upd.state         = cur_state;
		upd.missed        = cur_missed;
		if (cmd == mhbwd_pkg::CMD_HEARTBEAT) begin
			upd.state  = mhbwd_pkg::ST_FINE;
			upd.missed = '0;
		end else begin
			unique case (cur_state)
				mhbwd_pkg::ST_FINE: begin
					upd.state = mhbwd_pkg::ST_PAUSE;
				end
				mhbwd_pkg::ST_PAUSE: begin
					// A limit lowered below the count trips the slot on the next check.
					if (cur_missed < stop_limit) begin
						upd.missed = cur_missed + 1'b1;
					end else begin
						upd.state         = mhbwd_pkg::ST_STOP;
						upd.timeout_error = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Slots outside the table report all zero and change nothing.
	assign result = in_range ? upd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mhbwd_pkg::MODULES; i++) begin
				state_q[i]  <= mhbwd_pkg::ST_PAUSE;
				missed_q[i] <= '0;
			end
		end else if (valid && in_range) begin
			state_q[idx]  <= upd.state;
			missed_q[idx] <= upd.missed;
		end
	end

endmodule

// ===== src/module_heartbeat_watchdog.sv =====
// Top level of the per-module heartbeat watchdog: command register, limit register,
// result register. Depends on mhbwd_pkg and mhbwd_slot_table.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  command   | start / busy          | cmd, module_req
//  config    | cfg_valid / cfg_ready | cfg_data (stop_limit)
//  result    | done (strobe)         | timeout_error, new_state, missed_count
//
// A command is taken in every cycle in which busy is low; its result strobes on done.
// The slot read-modify-write happens combinationally between the command
// register and the result register, so back-to-back commands on one slot see fresh data.
// Reset puts every slot in pause with a zero count and the limit at 100.
// busy is high only in a cycle that carries a configuration beat.
module module_heartbeat_watchdog (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [mhbwd_pkg::REQ_W-1:0]       module_req,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mhbwd_pkg::COUNT_W-1:0]     cfg_data,
	output logic                              done,
	output logic                              timeout_error,
	output logic [1:0]                        new_state,
	output logic [mhbwd_pkg::COUNT_W-1:0]     missed_count
);

	logic                                 valid_s1;
	mhbwd_pkg::cmd_t                      cmd_s1;
	logic [mhbwd_pkg::REQ_W-1:0]          slot_s1;
	logic [mhbwd_pkg::COUNT_W-1:0]        stop_limit_q;
	mhbwd_pkg::slot_result_t              result;
	logic                                 done_s2;
	mhbwd_pkg::slot_result_t              result_s2;
	logic                                 accept;

	assign cfg_ready = 1'b1;
	// Holding off commands during a limit write keeps every check on one limit value.
	assign busy   = cfg_valid;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			stop_limit_q <= mhbwd_pkg::STOP_LIMIT_RESET;
			done_s2      <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_s2  <= valid_s1;
			if (cfg_valid && cfg_ready) begin
				stop_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= mhbwd_pkg::cmd_t'(cmd);
			slot_s1 <= module_req;
		end
		if (valid_s1) begin
			result_s2 <= result;
		end
	end

	mhbwd_slot_table u_slot_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.cmd        (cmd_s1),
		.slot       (slot_s1),
		.stop_limit (stop_limit_q),
		.result     (result)
	);

	assign done          = done_s2;
	assign timeout_error = result_s2.timeout_error;
	assign new_state     = result_s2.state;
	assign missed_count  = result_s2.missed;

endmodule

// ===== src/mhbwd_checker.sv =====
// Port-level checker for the heartbeat watchdog, bound to the top level.
// Depends on module_heartbeat_watchdog_macros.svh and mhbwd_pkg.
`include "module_heartbeat_watchdog_macros.svh"

module mhbwd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              cfg_valid,
	input logic                              done,
	input logic                              timeout_error,
	input logic [1:0]                        new_state,
	input logic [mhbwd_pkg::COUNT_W-1:0]     missed_count
);

	logic accept;
	assign accept = start && !busy;

	// Every accepted command yields exactly one result on done.
	`MHBWD_ASSERT_NEXT(a_result_follows, accept, ##1 done, "accepted command gave no result")
	`MHBWD_ASSERT_IMPL(a_no_spurious_result, done && arst_n, $past(accept, 2), "result without a command")
	// A timeout always reports the stop state.
	`MHBWD_ASSERT_IMPL(a_timeout_stop, done && timeout_error, new_state == mhbwd_pkg::ST_STOP, "timeout without stop")
	// A slot in fine has just seen a heartbeat, so its count is clear.
	`MHBWD_ASSERT_IMPL(a_fine_clear, done && new_state == mhbwd_pkg::ST_FINE, missed_count == '0 && !timeout_error, "fine slot with nonzero count")
	// Commands are held off while a limit beat is offered.
	`MHBWD_ASSERT_IMPL(a_cfg_holds_off, cfg_valid, busy, "command accepted during a limit write")

endmodule

bind module_heartbeat_watchdog mhbwd_checker u_mhbwd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cfg_valid     (cfg_valid),
	.done          (done),
	.timeout_error (timeout_error),
	.new_state     (new_state),
	.missed_count  (missed_count)
);

// ===== bench/tb_module_heartbeat_watchdog.sv =====
// Self-checking bench for module_heartbeat_watchdog: directed table and random phases.
// Each accepted command is predicted in-bench and compared with the strobed result.
// Depends on mhbwd_pkg and the watchdog RTL.
module tb_module_heartbeat_watchdog;
	import mhbwd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SHOWN_FAULTS = 10;

	typedef enum {ROW_CMD, ROW_LIMIT} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		cmd_t               op;
		logic [REQ_W-1:0]   slot;
		logic [COUNT_W-1:0] limit;
		bit                 pinned;
		slot_result_t       want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cmd_t               cmd;
	logic [REQ_W-1:0]   module_req;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data;
	logic               done;
	logic               timeout_error;
	logic [1:0]         new_state;
	logic [COUNT_W-1:0] missed_count;

	// Bench copy of the watchdog table and limit.
	slot_state_t        wd_state [MODULES];
	logic [COUNT_W-1:0] wd_missed [MODULES];
	logic [COUNT_W-1:0] wd_limit;

	slot_result_t slot_reports_due[$];
	plan_row_t    plan[$];

	// A typed expectation travels with the command beat that it belongs to.
	bit           pin_valid;
	slot_result_t pin_value;

	int idle_pct;
	int mismatches;
	int results_seen;
	int stops_seen;
	int limit_writes;
	int cycles;

	module_heartbeat_watchdog i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.module_req(module_req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.timeout_error(timeout_error),
		.new_state(new_state),
		.missed_count(missed_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic slot_result_t advance_slot(cmd_t op, logic [REQ_W-1:0] slot);
		slot_result_t r;
		int s;
		r = '0;
		s = int'(slot);
		if (s >= MODULES) return r;
		if (op == CMD_HEARTBEAT) begin
			wd_state[s] = ST_FINE;
			wd_missed[s] = '0;
		end else if (wd_state[s] == ST_FINE) begin
			wd_state[s] = ST_PAUSE;
		end else if (wd_state[s] == ST_PAUSE) begin
			if (wd_missed[s] < wd_limit) begin
				wd_missed[s] = wd_missed[s] + 1'b1;
			end else begin
				wd_state[s] = ST_STOP;
				r.timeout_error = 1'b1;
			end
		end
		r.state = wd_state[s];
		r.missed = wd_missed[s];
		return r;
	endfunction

	function automatic void plan_cmd(cmd_t op, int slot);
		plan_row_t row;
		row.kind = ROW_CMD;
		row.op = op;
		row.slot = slot[REQ_W-1:0];
		row.limit = '0;
		row.pinned = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_pin(cmd_t op, int slot, bit err, slot_state_t st, int count);
		plan_row_t row;
		row.kind = ROW_CMD;
		row.op = op;
		row.slot = slot[REQ_W-1:0];
		row.limit = '0;
		row.pinned = 1'b1;
		row.want.timeout_error = err;
		row.want.state = st;
		row.want.missed = count[COUNT_W-1:0];
		plan.push_back(row);
	endfunction

	function automatic void plan_limit(int value);
		plan_row_t row;
		row.kind = ROW_LIMIT;
		row.op = CMD_HEARTBEAT;
		row.slot = '0;
		row.limit = value[COUNT_W-1:0];
		row.pinned = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	task automatic issue_cmd(cmd_t op, logic [REQ_W-1:0] slot, bit pin, slot_result_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		module_req <= slot;
		pin_valid <= pin;
		pin_value <= want;
		do @(posedge clk); while (busy);
	endtask

	// The limit only changes once the table has gone quiet.
	task automatic write_limit(logic [COUNT_W-1:0] value);
		start <= 1'b0;
		do @(negedge clk); while (slot_reports_due.size() != 0);
		repeat (3 + $urandom_range(0, 2)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_writes++;
	endtask

	// Monitor: predicts every accepted command beat and checks every result strobe.
	always @(posedge clk) begin
		slot_result_t got;
		slot_result_t want;
		if (arst_n) begin
			if (done) begin
				got.timeout_error = timeout_error;
				got.state = slot_state_t'(new_state);
				got.missed = missed_count;
				results_seen++;
				if (timeout_error) stops_seen++;
				if (slot_reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_FAULTS)
						$display("unexpected result: err=%0d state=%0d count=%0d",
							got.timeout_error, got.state, got.missed);
				end else begin
					want = slot_reports_due.pop_front();
					if (got.timeout_error !== want.timeout_error || got.state !== want.state ||
							got.missed !== want.missed) begin
						mismatches++;
						if (mismatches <= SHOWN_FAULTS)
							$display("mismatch: expected err=%0d state=%0d count=%0d, got err=%0d state=%0d count=%0d",
								want.timeout_error, want.state, want.missed,
								got.timeout_error, got.state, got.missed);
					end
				end
			end
			if (cfg_valid && cfg_ready) wd_limit = cfg_data;
			if (start && !busy) begin
				want = advance_slot(cmd, module_req);
				if (pin_valid) want = pin_value;
				slot_reports_due.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[module_heartbeat_watchdog] ERROR");
			$finish;
		end
	end

	initial begin
		int p;
		int n;
		int hot;
		logic [COUNT_W-1:0] lim;
		cmd_t op;
		logic [REQ_W-1:0] slot;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_HEARTBEAT;
		module_req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		pin_valid = 1'b0;
		pin_value = '0;
		idle_pct = 33;
		mismatches = 0;
		results_seen = 0;
		stops_seen = 0;
		limit_writes = 0;
		cycles = 0;
		wd_limit = STOP_LIMIT_RESET;
		for (int i = 0; i < MODULES; i++) begin
			wd_state[i] = ST_PAUSE;
			wd_missed[i] = '0;
		end

		// Directed table; typed expectations where the outcome is obvious.
		plan_pin(CMD_CHECK, 0, 1'b0, ST_PAUSE, 1);
		plan_pin(CMD_HEARTBEAT, 0, 1'b0, ST_FINE, 0);
		plan_pin(CMD_CHECK, 0, 1'b0, ST_PAUSE, 0);
		plan_pin(CMD_HEARTBEAT, 15, 1'b0, ST_FINE, 0);
		plan_pin(CMD_CHECK, 15, 1'b0, ST_PAUSE, 0);
		plan_limit(0);
		plan_pin(CMD_CHECK, 0, 1'b1, ST_STOP, 0);
		plan_pin(CMD_CHECK, 0, 1'b0, ST_STOP, 0);
		plan_pin(CMD_HEARTBEAT, 0, 1'b0, ST_FINE, 0);
		plan_pin(CMD_CHECK, 10, 1'b1, ST_STOP, 0);
		plan_limit(2);
		plan_cmd(CMD_CHECK, 5);
		plan_cmd(CMD_CHECK, 5);
		plan_pin(CMD_CHECK, 5, 1'b1, ST_STOP, 2);
		plan_limit(65535);
		plan_cmd(CMD_CHECK, 6);
		plan_cmd(CMD_CHECK, 6);
		plan_cmd(CMD_CHECK, 6);
		// Limit drops below the count that slot 6 has already reached.
		plan_limit(1);
		plan_pin(CMD_CHECK, 6, 1'b1, ST_STOP, 3);
		plan_pin(CMD_HEARTBEAT, 5, 1'b0, ST_FINE, 0);
		plan_cmd(CMD_CHECK, 5);
		plan_cmd(CMD_CHECK, 10);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_LIMIT) write_limit(plan[i].limit);
			else issue_cmd(plan[i].op, plan[i].slot, plan[i].pinned, plan[i].want);
		end

		// Random phases, each with its own limit and a cluster of busy slots.
		for (p = 0; p < 10; p++) begin
			if (p == 0) lim = '0;
			else if (p == 1) lim = '1;
			else if (p == 2) lim = 16'd1;
			else if ($urandom_range(0, 3) == 0) lim = COUNT_W'($urandom_range(0, 65535));
			else lim = COUNT_W'($urandom_range(0, 12));
			write_limit(lim);
			idle_pct = (p == 4) ? 0 : 33;
			hot = int'($urandom_range(0, MODULES - 4));
			for (n = 0; n < 85; n++) begin
				op = ($urandom_range(0, 99) < 25) ? CMD_HEARTBEAT : CMD_CHECK;
				if ($urandom_range(0, 3) != 0) slot = REQ_W'(hot + $urandom_range(0, 3));
				else slot = REQ_W'($urandom_range(0, MODULES - 1));
				issue_cmd(op, slot, 1'b0, '0);
			end
		end

		start <= 1'b0;
		do @(negedge clk); while (slot_reports_due.size() != 0);
		repeat (4) @(posedge clk);

		$display("covered %0d results (%0d timeouts) across %0d limit settings",
			results_seen, stops_seen, limit_writes);
		if (mismatches == 0) begin
			$display("[module_heartbeat_watchdog] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[module_heartbeat_watchdog] ERROR");
		end
		$finish;
	end
endmodule
